@@ sv/montgomery_modular_exponentiation_assert.svh @@
// assertion macros for the montgomery exponentiation block
// the using module provides clk and rst_n
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_ASSERT_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ sv/mme_pkg.sv @@
`default_nettype none

package mme_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_BITLEN,
        S_WORDS,
        S_INV_A,
        S_INV_B,
        S_INV_C,
        S_DIV,
        S_DBL_A,
        S_DBL_X,
        S_MONT_INIT,
        M_XY,
        M_MN,
        M_TAIL,
        M_W1,
        M_Q,
        M_Q2,
        M_W2,
        M_SH,
        M_W3,
        M_HI,
        M_SUB,
        M_SEL,
        S_EXP_NEXT
    } state_t;

    // which montgomery product is running
    typedef enum logic [1:0] {
        OP_SQR,
        OP_MULA,
        OP_FINAL
    } op_t;

    // newton steps for the inverse of the modulus mod 2^w
    localparam int NEWTON_STEPS = 6;

endpackage

`default_nettype wire

@@ sv/mme_mul.sv @@
`default_nettype none

module mme_mul #(
    parameter int WORD_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic [WORD_BITS-1:0]     a,
    input  wire logic [WORD_BITS-1:0]     b,
    output logic      [2*WORD_BITS-1:0]   prod
);

    logic [2*WORD_BITS-1:0] prod_reg;

    // registered word multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= (2*WORD_BITS)'(a) * (2*WORD_BITS)'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ sv/montgomery_modular_exponentiation.sv @@
`default_nettype none
// montgomery modular exponentiation: result = base^exponent mod modulus
// command port: a word is taken at a clock edge where start is high and busy
// is low. busy stays high until the result is out. done is high for exactly
// one cycle with result and bad_modulus valid; the receiver cannot stall, so
// the word must be taken in that cycle.
// an even modulus or one below 3 gives bad_modulus = 1 and result = 0, with
// done registered from the S_CHECK state that the accepting edge enters.
// otherwise the run goes through these steps: bit length, n' by newton,
// base mod n bit-serial, two domain conversions by doubling, then k
// squarings, one product per set bit among the low k exponent bits and
// one final product. the single registered word multiplier is shared by
// the newton steps and the montgomery products, which work on
// s = ceil(k/WORD_BITS) words.
// one item at a time; rst_n clears the sequencer to idle, no results pending.
`include "montgomery_modular_exponentiation_assert.svh"

module montgomery_modular_exponentiation
    import mme_pkg::*;
#(
    parameter int MOD_BITS  = 64,
    parameter int WORD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic [63:0] base,
    input  wire logic [63:0] exponent,
    input  wire logic [63:0] modulus,
    output logic      [63:0] result,
    output logic             bad_modulus
);

    localparam int NW   = (MOD_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int VB   = NW * WORD_BITS;
    localparam int CW   = $clog2(2 * NW + 1);
    localparam int IW   = $clog2(NW + 1);
    localparam int KW   = $clog2(MOD_BITS + 1);
    localparam int KBW  = $clog2(MOD_BITS);
    localparam int CNTW = $clog2(MOD_BITS + WORD_BITS + 65);
    localparam int AW   = 2 * WORD_BITS + 9;
    localparam int W    = WORD_BITS;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [MOD_BITS-1:0]    n_reg, n_next;
    logic [63:0]            e_reg, e_next;
    logic [63:0]            base_reg, base_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [IW-1:0]          s_reg, s_next;
    logic [CNTW-1:0]        t_reg, t_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [W-1:0]           inv_reg, inv_next;
    logic [W-1:0]           nprime_reg, nprime_next;
    logic [MOD_BITS:0]      r_reg, r_next;
    logic [VB-1:0]          abar_reg, abar_next;
    logic [VB-1:0]          x_reg, x_next;
    logic [VB-1:0]          m_reg, m_next;
    logic [VB-1:0]          d_reg, d_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic                   pend_reg, pend_next;
    logic                   borrow_reg, borrow_next;
    logic [KBW-1:0]         ei_reg, ei_next;
    logic [63:0]            result_reg, result_next;
    logic                   bad_reg, bad_next;
    logic                   done_reg, done_next;

    logic [W-1:0]           mul_a, mul_b;
    logic [2*W-1:0]         prod;
    logic [VB-1:0]          nvec, yvec;
    logic [CW-1:0]          s_c, ip1, jlo_ip1, jhi;
    logic [MOD_BITS:0]      r_dbl, r_div;
    logic [W:0]             sub_w;
    logic [W-1:0]           mw;

    function automatic logic [W-1:0] word_at(input logic [VB-1:0] v,
                                             input logic [CW-1:0] idx);
        return v[idx*W +: W];
    endfunction

    // shared word multiplier
    mme_mul #(.WORD_BITS(WORD_BITS)) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // operand views and column limits
    always_comb
    begin
        nvec = VB'(n_reg);
        case (op_reg)
            OP_SQR:   yvec = x_reg;
            OP_MULA:  yvec = abar_reg;
            OP_FINAL: yvec = VB'(1);
            default:  yvec = x_reg;
        endcase
        s_c     = CW'(s_reg);
        ip1     = i_reg + CW'(1);
        jlo_ip1 = (ip1 < s_c) ? '0 : ip1 - s_c + CW'(1);
        jhi     = (i_reg < s_c) ? i_reg : s_c;
        r_dbl   = {r_reg[MOD_BITS-1:0], 1'b0};
        if (r_dbl >= {1'b0, n_reg})
        begin
            r_dbl = r_dbl - {1'b0, n_reg};
        end
        r_div   = {r_reg[MOD_BITS-1:0], base_reg[63]};
        if (r_div >= {1'b0, n_reg})
        begin
            r_div = r_div - {1'b0, n_reg};
        end
        mw      = word_at(m_reg, j_reg);
        sub_w   = {1'b0, word_at(nvec, j_reg)} + (W+1)'(borrow_reg);
    end

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        n_reg      <= n_next;
        e_reg      <= e_next;
        base_reg   <= base_next;
        k_reg      <= k_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        cnt_reg    <= cnt_next;
        inv_reg    <= inv_next;
        nprime_reg <= nprime_next;
        r_reg      <= r_next;
        abar_reg   <= abar_next;
        x_reg      <= x_next;
        m_reg      <= m_next;
        d_reg      <= d_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        borrow_reg <= borrow_next;
        ei_reg     <= ei_next;
        result_reg <= result_next;
        bad_reg    <= bad_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        n_next      = n_reg;
        e_next      = e_reg;
        base_next   = base_reg;
        k_next      = k_reg;
        s_next      = s_reg;
        t_next      = t_reg;
        cnt_next    = cnt_reg;
        inv_next    = inv_reg;
        nprime_next = nprime_reg;
        r_next      = r_reg;
        abar_next   = abar_reg;
        x_next      = x_reg;
        m_next      = m_reg;
        d_next      = d_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        acc_next    = pend_reg ? acc_reg + AW'(prod) : acc_reg;
        borrow_next = borrow_reg;
        ei_next     = ei_reg;
        result_next = result_reg;
        bad_next    = bad_reg;
        done_next   = 1'b0;
        pend_next   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = modulus[MOD_BITS-1:0];
                    e_next     = exponent;
                    base_next  = base;
                    state_next = S_CHECK;
                end
            end

            // reject even or tiny modulus
            S_CHECK:
            begin
                if (!n_reg[0] || n_reg < MOD_BITS'(3))
                begin
                    result_next = '0;
                    bad_next    = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    k_next     = KW'(MOD_BITS);
                    state_next = S_BITLEN;
                end
            end

            // bit length, one bit per cycle from the top
            S_BITLEN:
            begin
                if (!n_reg[KBW'(k_reg - KW'(1))])
                begin
                    k_next = k_reg - KW'(1);
                end
                else
                begin
                    t_next     = '0;
                    s_next     = '0;
                    state_next = S_WORDS;
                end
            end

            // word count s = ceil(k / w), t = s * w
            S_WORDS:
            begin
                if (t_reg < CNTW'(k_reg))
                begin
                    t_next = t_reg + CNTW'(W);
                    s_next = s_reg + IW'(1);
                end
                else
                begin
                    inv_next   = W'(1);
                    cnt_next   = '0;
                    state_next = S_INV_A;
                end
            end

            // newton iteration for n^-1 mod 2^w
            S_INV_A:
            begin
                mul_a      = nvec[W-1:0];
                mul_b      = inv_reg;
                state_next = S_INV_B;
            end

            S_INV_B:
            begin
                mul_a      = inv_reg;
                mul_b      = W'(2) - prod[W-1:0];
                state_next = S_INV_C;
            end

            S_INV_C:
            begin
                inv_next = prod[W-1:0];
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(NEWTON_STEPS - 1))
                begin
                    nprime_next = W'(0) - prod[W-1:0];
                    cnt_next    = '0;
                    r_next      = '0;
                    state_next  = S_DIV;
                end
                else
                begin
                    state_next = S_INV_A;
                end
            end

            // base mod n, restoring, one bit per cycle
            S_DIV:
            begin
                r_next    = r_div;
                base_next = {base_reg[62:0], 1'b0};
                cnt_next  = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(63))
                begin
                    cnt_next   = '0;
                    state_next = S_DBL_A;
                end
            end

            // a * R mod n by doubling
            S_DBL_A:
            begin
                if (cnt_reg == t_reg)
                begin
                    abar_next  = VB'(r_reg[MOD_BITS-1:0]);
                    r_next     = (MOD_BITS+1)'(1);
                    cnt_next   = '0;
                    state_next = S_DBL_X;
                end
                else
                begin
                    r_next   = r_dbl;
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            // R mod n by doubling
            S_DBL_X:
            begin
                if (cnt_reg == t_reg)
                begin
                    x_next     = VB'(r_reg[MOD_BITS-1:0]);
                    ei_next    = KBW'(k_reg - KW'(1));
                    op_next    = OP_SQR;
                    state_next = S_MONT_INIT;
                end
                else
                begin
                    r_next   = r_dbl;
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            // montgomery product setup
            S_MONT_INIT:
            begin
                acc_next   = '0;
                i_next     = '0;
                j_next     = '0;
                m_next     = '0;
                d_next     = '0;
                state_next = M_XY;
            end

            // column inner loop: x*y term
            M_XY:
            begin
                if (j_reg < jhi)
                begin
                    mul_a      = word_at(x_reg, j_reg);
                    mul_b      = word_at(yvec, i_reg - j_reg);
                    pend_next  = 1'b1;
                    state_next = M_MN;
                end
                else
                begin
                    state_next = M_TAIL;
                end
            end

            // column inner loop: m*n term
            M_MN:
            begin
                mul_a      = mw;
                mul_b      = word_at(nvec, i_reg - j_reg);
                pend_next  = 1'b1;
                j_next     = j_reg + CW'(1);
                state_next = M_XY;
            end

            M_TAIL:
            begin
                if (i_reg < s_c)
                begin
                    mul_a      = word_at(x_reg, i_reg);
                    mul_b      = yvec[W-1:0];
                    pend_next  = 1'b1;
                    state_next = M_W1;
                end
                else
                begin
                    state_next = M_W3;
                end
            end

            M_W1:
            begin
                state_next = M_Q;
            end

            // quotient word m[i] = acc * n'
            M_Q:
            begin
                mul_a      = acc_reg[W-1:0];
                mul_b      = nprime_reg;
                state_next = M_Q2;
            end

            M_Q2:
            begin
                m_next[i_reg*W +: W] = prod[W-1:0];
                mul_a      = prod[W-1:0];
                mul_b      = nvec[W-1:0];
                pend_next  = 1'b1;
                state_next = M_W2;
            end

            M_W2:
            begin
                state_next = M_SH;
            end

            M_SH:
            begin
                acc_next   = acc_reg >> W;
                i_next     = ip1;
                j_next     = jlo_ip1;
                state_next = M_XY;
            end

            M_W3:
            begin
                state_next = M_HI;
            end

            // upper columns give the result words
            M_HI:
            begin
                m_next[(i_reg - s_c)*W +: W] = acc_reg[W-1:0];
                acc_next = acc_reg >> W;
                if (ip1 == (s_c << 1))
                begin
                    j_next      = '0;
                    borrow_next = 1'b0;
                    state_next  = M_SUB;
                end
                else
                begin
                    i_next     = ip1;
                    j_next     = jlo_ip1;
                    state_next = M_XY;
                end
            end

            // word-serial trial subtraction of n
            M_SUB:
            begin
                if (j_reg < s_c)
                begin
                    d_next[j_reg*W +: W] = mw - sub_w[W-1:0];
                    borrow_next = ({1'b0, mw} < sub_w);
                    j_next      = j_reg + CW'(1);
                end
                else
                begin
                    state_next = M_SEL;
                end
            end

            M_SEL:
            begin
                x_next     = (acc_reg == '0 && borrow_reg) ? m_reg : d_reg;
                state_next = S_EXP_NEXT;
            end

            // square-and-multiply control
            S_EXP_NEXT:
            begin
                state_next = S_MONT_INIT;
                if (op_reg == OP_FINAL)
                begin
                    result_next = 64'(x_reg);
                    bad_next    = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (op_reg == OP_SQR && e_reg[ei_reg])
                begin
                    op_next = OP_MULA;
                end
                else if (ei_reg == '0)
                begin
                    op_next = OP_FINAL;
                end
                else
                begin
                    ei_next = ei_reg - KBW'(1);
                    op_next = OP_SQR;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result      = result_reg;
    assign bad_modulus = bad_reg;

    `ASSERT_PROP(a_done_pulse, done |=> !done)
    `ASSERT_PROP(a_bad_zero, done && bad_modulus |-> result == 64'd0)
    `ASSERT_PROP(a_accept_busy, start && !busy |=> busy)
    `ASSERT_NEVER(a_done_busy, done && busy)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOD_BITS   = 64;
    localparam int WORD_BITS  = 16;
    localparam int RAND_ITEMS = 120;
    localparam int IDLE_LIMIT = 60000;
    localparam int DRAIN_CYC  = 50;

    typedef struct {
        logic [63:0] result;
        logic        bad;
    } power_t;

    typedef struct {
        logic [63:0] base;
        logic [63:0] exponent;
        logic [63:0] modulus;
        bit          known;
        logic [63:0] result;
        logic        bad;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [63:0] base;
    logic [63:0] exponent;
    logic [63:0] modulus;
    logic [63:0] result;
    logic        bad_modulus;

    power_t  power_q[$];
    vector_t vectors[$];
    int      err_cnt;
    int      taken_cnt;
    int      idle_cnt;

    montgomery_modular_exponentiation #(
        .MOD_BITS  (MOD_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .base        (base),
        .exponent    (exponent),
        .modulus     (modulus),
        .result      (result),
        .bad_modulus (bad_modulus)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // (x * y) mod n on a double-width product
    function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] n);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return 64'(p % {64'd0, n});
    endfunction

    // base^exponent mod modulus, scanning only the low k exponent bits
    function automatic power_t mod_power(input logic [63:0] b, input logic [63:0] e,
                                         input logic [63:0] m);
        power_t      p;
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] acc;
        int          k;
        n = (MOD_BITS == 64) ? m : (m & ((64'd1 << MOD_BITS) - 1));
        p.result = '0;
        p.bad    = 1'b0;
        if (!n[0] || n < 3)
        begin
            p.bad = 1'b1;
            return p;
        end
        k = 0;
        while (k < 64 && (n >> k) != 0)
            k++;
        a   = b % n;
        acc = 64'd1;
        for (int i = k - 1; i >= 0; i--)
        begin
            acc = mul_mod(acc, acc, n);
            if (e[i])
                acc = mul_mod(acc, a, n);
        end
        p.result = acc;
        return p;
    endfunction

    function automatic vector_t row(input logic [63:0] b, input logic [63:0] e,
                                    input logic [63:0] m, input bit known,
                                    input logic [63:0] r, input logic bad);
        vector_t v;
        v.base = b; v.exponent = e; v.modulus = m;
        v.known = known; v.result = r; v.bad = bad;
        return v;
    endfunction

    // accept words and check results at the rising edge
    always @(posedge clk)
    begin
        power_t p;
        bit     moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                taken_cnt = taken_cnt + 1;
                moved     = 1'b1;
            end
            if (done)
            begin
                moved = 1'b1;
                if (power_q.size() == 0)
                    report("result word with nothing expected");
                else
                begin
                    p = power_q.pop_front();
                    if (result !== p.result)
                        report($sformatf("result %h, expected %h", result, p.result));
                    if (bad_modulus !== p.bad)
                        report($sformatf("bad_modulus %b, expected %b", bad_modulus, p.bad));
                end
            end
            idle_cnt <= moved ? 0 : idle_cnt + 1;
        end
        else
            idle_cnt <= 0;
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        vector_t v;
        power_t  p;
        int      burst_left;
        int      gap;
        int      k;
        int      sent;
        logic [63:0] m;

        err_cnt   = 0;
        taken_cnt = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        base      = '0;
        exponent  = '0;
        modulus   = '0;

        // directed words: bad moduli, extremes, ignored exponent bits
        vectors.push_back(row(64'd5, 64'd3, 64'd0, 1, 64'd0, 1'b1));
        vectors.push_back(row(64'd5, 64'd3, 64'd1, 1, 64'd0, 1'b1));
        vectors.push_back(row(64'd5, 64'd3, 64'd2, 1, 64'd0, 1'b1));
        vectors.push_back(row('1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1, 64'd0, 1'b1));
        vectors.push_back(row(64'd0, 64'd0, 64'd3, 1, 64'd1, 1'b0));
        vectors.push_back(row('1, 64'd0, '1, 1, 64'd1, 1'b0));
        vectors.push_back(row('1, '1, '1, 1, 64'd0, 1'b0));
        vectors.push_back(row(64'd0, 64'd5, 64'd7, 1, 64'd0, 1'b0));
        vectors.push_back(row(64'd2, 64'd10, 64'd1023, 1, 64'd1, 1'b0));
        vectors.push_back(row(64'd3, 64'd8, 64'd7, 1, 64'd1, 1'b0));
        vectors.push_back(row(64'd3, 64'hFFFF_FFFF_FFFF_FFF8, 64'd7, 1, 64'd1, 1'b0));
        vectors.push_back(row(64'd1, '1, 64'hFFFF_FFFF_FFFF_FFC5, 1, 64'd1, 1'b0));
        vectors.push_back(row(64'd12345, 64'd1, 64'd65521, 0, '0, 1'b0));
        vectors.push_back(row('1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0001, 0, '0, 1'b0));
        vectors.push_back(row(64'h5555_5555_5555_5555, '1, 64'hFFFF_FFFF_FFFF_FFC5, 0, '0, 1'b0));
        vectors.push_back(row(64'hDEAD_BEEF_0123_4567, 64'd65537, 64'h0001_0001, 0, '0, 1'b0));
        vectors.push_back(row(64'd7, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0, 1'b0));

        // random words, mostly short moduli to keep runs brief
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            k = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 24) : $urandom_range(25, 64);
            m = {$urandom, $urandom};
            if (k < 64)
                m = m & ((64'd1 << k) - 1);
            m[k - 1] = 1'b1;
            if ($urandom_range(0, 9) != 0)
                m[0] = 1'b1;
            vectors.push_back(row({$urandom, $urandom},
                                  ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 255))
                                                              : {$urandom, $urandom},
                                  m, 0, '0, 1'b0));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // send words in bursts with random gaps
        burst_left = 0;
        sent       = 0;
        foreach (vectors[i])
        begin
            v = vectors[i];
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 6);
                gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                start      = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left--;
            if (v.known)
            begin
                p.result = v.result;
                p.bad    = v.bad;
            end
            else
                p = mod_power(v.base, v.exponent, v.modulus);
            base     = v.base;
            exponent = v.exponent;
            modulus  = v.modulus;
            start    = 1'b1;
            power_q.push_back(p);
            sent++;
            while (taken_cnt < sent)
                @(negedge clk);
        end
        start = 1'b0;

        // drain
        while (power_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
